### rtl/udc_pkg.sv
// ============================================================================
// udc_pkg: shared types and constants of the Unix time calendar converter
// Word layouts, mode codes, reciprocal constants and the month table.
// ============================================================================
package udc_pkg;

  // Mode codes of the input word.
  localparam logic MODE_TO_CAL  = 1'b0;
  localparam logic MODE_TO_SECS = 1'b1;

  // Number of register stages between input and output.
  localparam int NUM_STAGES = 8;
  // Stage at which the calendar-to-seconds sum is folded into the word.
  localparam int CAL_STAGE  = 2;

  localparam int DAYS_W = 16;  // day count since 2000-01-01
  localparam int SOD_W  = 17;  // second of day

  localparam logic [31:0] EPOCH_2000   = 32'd946684800;
  localparam logic [31:0] EPOCH_2100   = 32'd4102444800;
  // 2000 offset minus one day: the calendar sum counts day 1 as one day.
  localparam logic [31:0] CAL_OFFSET   = 32'd946598400;
  localparam logic [16:0] SECS_PER_DAY = 17'd86400;
  localparam logic [11:0] SECS_PER_HR  = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN = 6'd60;
  localparam logic [10:0] DAYS_PER_QUAD = 11'd1461;
  localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;

  // Reciprocal multipliers; the shift is the product bit where the quotient starts.
  localparam logic [31:0] DAY_RECIP   = 32'd3257812230;  // floor(2^48 / 86400)
  localparam int          DAY_SHIFT   = 48;
  localparam logic [15:0] HOUR_RECIP  = 16'd37283;       // ceil(2^27 / 3600)
  localparam int          HOUR_SHIFT  = 27;
  localparam logic [12:0] MIN_RECIP   = 13'd4370;        // ceil(2^18 / 60)
  localparam int          MIN_SHIFT   = 18;
  localparam logic [17:0] QUAD_RECIP  = 18'd183735;      // ceil(2^28 / 1461)
  localparam int          QUAD_SHIFT  = 28;

  // Day-of-year where the second, third and fourth year of a leap quad start.
  localparam logic [10:0] QUAD_Y1 = 11'd366;
  localparam logic [10:0] QUAD_Y2 = 11'd731;
  localparam logic [10:0] QUAD_Y3 = 11'd1096;

  typedef struct packed {
    logic        mode;
    logic [31:0] epoch_seconds;
    logic [6:0]  year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } in_word_t;

  typedef struct packed {
    logic [31:0] out_epoch_seconds;
    logic [6:0]  out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic [5:0]  out_second;
    logic        out_of_range;
  } out_word_t;

  // What travels alongside the arithmetic in every stage.
  typedef struct packed {
    in_word_t word;
    logic     oor;
  } carry_t;

  // Days of a common year before month index mo; past December counts a full year.
  function automatic logic [8:0] days_before_month(input logic [3:0] mo);
    logic [8:0] d;
    unique case (mo)
      4'd0, 4'd1: d = 9'd0;
      4'd2:       d = 9'd31;
      4'd3:       d = 9'd59;
      4'd4:       d = 9'd90;
      4'd5:       d = 9'd120;
      4'd6:       d = 9'd151;
      4'd7:       d = 9'd181;
      4'd8:       d = 9'd212;
      4'd9:       d = 9'd243;
      4'd10:      d = 9'd273;
      4'd11:      d = 9'd304;
      4'd12:      d = 9'd334;
      default:    d = 9'd365;
    endcase
    return d;
  endfunction

endpackage

### rtl/udc_in_if.sv
// ============================================================================
// udc_in_if: input channel of the converter
// Valid/ready handshake carrying one input word.
// ============================================================================
interface udc_in_if;
  logic             valid;
  logic             ready;
  udc_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/udc_out_if.sv
// ============================================================================
// udc_out_if: output channel of the converter
// Valid/ready handshake carrying one result word.
// ============================================================================
interface udc_out_if;
  logic              valid;
  logic              ready;
  udc_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/udc_sec_split.sv
// ============================================================================
// udc_sec_split: epoch seconds to day count and second of day
// Four stages: offset, reciprocal multiply, remainder, one-step correction.
// ============================================================================
module udc_sec_split (
  input  logic                        clk,
  input  logic [3:0]                  en,
  input  logic [31:0]                 epoch_seconds,
  output logic [udc_pkg::DAYS_W-1:0]  days,
  output logic [udc_pkg::SOD_W-1:0]   sod
);

  logic [31:0]                 t0;
  logic [31:0]                 t1;
  logic [udc_pkg::DAYS_W-1:0]  dq1;
  logic [udc_pkg::DAYS_W-1:0]  dq2;
  logic [udc_pkg::SOD_W:0]     rem2;
  logic [63:0]                 prod;
  logic [31:0]                 rem_full;

  // The estimate is at most one below the true quotient.
  assign prod     = 64'(t0) * 64'(udc_pkg::DAY_RECIP);
  assign rem_full = t1 - (32'(dq1) * 32'(udc_pkg::SECS_PER_DAY));

  always_ff @(posedge clk) begin
    if (en[0]) begin
      t0 <= epoch_seconds - udc_pkg::EPOCH_2000;
    end
    if (en[1]) begin
      t1  <= t0;
      dq1 <= prod[udc_pkg::DAY_SHIFT +: udc_pkg::DAYS_W];
    end
    if (en[2]) begin
      dq2  <= dq1;
      rem2 <= rem_full[udc_pkg::SOD_W:0];
    end
    if (en[3]) begin
      if (rem2 >= (udc_pkg::SOD_W+1)'(udc_pkg::SECS_PER_DAY)) begin
        days <= dq2 + udc_pkg::DAYS_W'(1);
        sod  <= udc_pkg::SOD_W'(rem2 - (udc_pkg::SOD_W+1)'(udc_pkg::SECS_PER_DAY));
      end else begin
        days <= dq2;
        sod  <= rem2[udc_pkg::SOD_W-1:0];
      end
    end
  end

endmodule

### rtl/udc_tod_split.sv
// ============================================================================
// udc_tod_split: second of day to hour, minute and second
// Four stages alternating a reciprocal multiply and a remainder.
// ============================================================================
module udc_tod_split (
  input  logic                       clk,
  input  logic [3:0]                 en,
  input  logic [udc_pkg::SOD_W-1:0]  sod,
  output logic [4:0]                 hour,
  output logic [5:0]                 minute,
  output logic [5:0]                 second
);

  logic [udc_pkg::SOD_W-1:0] sod4;
  logic [4:0]                h4;
  logic [4:0]                h5;
  logic [4:0]                h6;
  logic [11:0]               rh5;
  logic [11:0]               rh6;
  logic [5:0]                mi6;
  logic [32:0]               hprod;
  logic [24:0]               mprod;
  logic [16:0]               rh_full;
  logic [11:0]               se_full;

  assign hprod   = 33'(sod) * 33'(udc_pkg::HOUR_RECIP);
  assign rh_full = sod4 - (17'(h4) * 17'(udc_pkg::SECS_PER_HR));
  assign mprod   = 25'(rh5) * 25'(udc_pkg::MIN_RECIP);
  assign se_full = rh6 - (12'(mi6) * 12'(udc_pkg::SECS_PER_MIN));

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sod4 <= sod;
      h4   <= hprod[udc_pkg::HOUR_SHIFT +: 5];
    end
    if (en[1]) begin
      h5  <= h4;
      rh5 <= rh_full[11:0];
    end
    if (en[2]) begin
      h6  <= h5;
      rh6 <= rh5;
      mi6 <= mprod[udc_pkg::MIN_SHIFT +: 6];
    end
    if (en[3]) begin
      hour   <= h6;
      minute <= mi6;
      second <= se_full[5:0];
    end
  end

endmodule

### rtl/udc_date_split.sv
// ============================================================================
// udc_date_split: day count since 2000 to year, month and day
// Four stages: leap quad estimate, day in quad, year in quad, month search.
// ============================================================================
module udc_date_split (
  input  logic                       clk,
  input  logic [3:0]                 en,
  input  logic [udc_pkg::DAYS_W-1:0] days,
  output logic [6:0]                 year,
  output logic [3:0]                 month,
  output logic [4:0]                 day
);

  logic [udc_pkg::DAYS_W-1:0] days4;
  logic [4:0]                 q4;
  logic [4:0]                 q5;
  logic [10:0]                r5;
  logic [6:0]                 yr6;
  logic [8:0]                 doy6;
  logic                       leap6;
  logic [33:0]                qprod;
  logic [15:0]                r_full;
  logic [1:0]                 yy;
  logic [10:0]                doy_sel;
  logic [3:0]                 mon_idx;
  logic [8:0]                 mon_start;
  logic [8:0]                 thr;
  logic [8:0]                 dd;

  assign qprod  = 34'(days) * 34'(udc_pkg::QUAD_RECIP);
  assign r_full = days4 - (16'(q4) * 16'(udc_pkg::DAYS_PER_QUAD));

  // Year inside the quad; the first year of each quad is the leap year.
  always_comb begin
    priority if (r5 < udc_pkg::QUAD_Y1) begin
      yy      = 2'd0;
      doy_sel = r5;
    end else if (r5 < udc_pkg::QUAD_Y2) begin
      yy      = 2'd1;
      doy_sel = r5 - udc_pkg::QUAD_Y1;
    end else if (r5 < udc_pkg::QUAD_Y3) begin
      yy      = 2'd2;
      doy_sel = r5 - udc_pkg::QUAD_Y2;
    end else begin
      yy      = 2'd3;
      doy_sel = r5 - udc_pkg::QUAD_Y3;
    end
  end

  // Month starts rise, so the last start not above the day wins.
  always_comb begin
    mon_idx   = 4'd0;
    mon_start = 9'd0;
    thr       = 9'd0;
    for (int m = 1; m < 12; m++) begin
      thr = udc_pkg::days_before_month(4'(m + 1)) + 9'(leap6 && (m >= 2));
      if (doy6 >= thr) begin
        mon_idx   = 4'(m);
        mon_start = thr;
      end
    end
    dd = doy6 - mon_start + 9'd1;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      days4 <= days;
      q4    <= qprod[udc_pkg::QUAD_SHIFT +: 5];
    end
    if (en[1]) begin
      q5 <= q4;
      r5 <= r_full[10:0];
    end
    if (en[2]) begin
      yr6   <= {q5, 2'b00} + 7'(yy);
      doy6  <= doy_sel[8:0];
      leap6 <= (yy == 2'd0);
    end
    if (en[3]) begin
      year  <= yr6;
      month <= mon_idx + 4'd1;
      day   <= dd[4:0];
    end
  end

endmodule

### rtl/udc_cal_sum.sv
// ============================================================================
// udc_cal_sum: calendar fields to seconds since 1970
// Two stages: day and second-of-day sums, then the day multiply.
// ============================================================================
module udc_cal_sum (
  input  logic        clk,
  input  logic [1:0]  en,
  input  logic [6:0]  year,
  input  logic [3:0]  month,
  input  logic [4:0]  day,
  input  logic [4:0]  hour,
  input  logic [5:0]  minute,
  input  logic [5:0]  second,
  output logic [31:0] epoch_seconds
);

  logic [udc_pkg::DAYS_W-1:0] days_plus;
  logic [udc_pkg::DAYS_W-1:0] days0;
  logic [udc_pkg::SOD_W-1:0]  hms;
  logic [udc_pkg::SOD_W-1:0]  hms0;
  logic [udc_pkg::SOD_W-1:0]  hms1;
  logic [31:0]                prod1;
  logic [32:0]                day_prod;
  logic                       leap_add;

  assign leap_add  = (month > 4'd2) && (year[1:0] == 2'b00);
  // Day count plus one: day 1 of 2000-01 gives one, folded into the offset.
  assign days_plus = 16'(day) + 16'(udc_pkg::days_before_month(month)) + 16'(leap_add)
                   + 16'(year) * 16'(udc_pkg::DAYS_PER_YEAR)
                   + 16'((8'(year) + 8'd3) >> 2);
  assign hms       = 17'(hour) * 17'(udc_pkg::SECS_PER_HR)
                   + 17'(minute) * 17'(udc_pkg::SECS_PER_MIN) + 17'(second);
  assign day_prod  = 33'(days0) * 33'(udc_pkg::SECS_PER_DAY);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      days0 <= days_plus;
      hms0  <= hms;
    end
    if (en[1]) begin
      prod1 <= day_prod[31:0];
      hms1  <= hms0;
    end
  end

  assign epoch_seconds = prod1 + 32'(hms1) + udc_pkg::CAL_OFFSET;

endmodule

### rtl/unix_time_calendar_converter_core.sv
// ============================================================================
// unix_time_calendar_converter_core: epoch seconds <-> calendar, 2000..2099
// Eight-stage pipeline converting in the direction each word's mode selects.
// ============================================================================
// The converter takes one word per clock while the output side is ready and
// returns one result word for each, in order, from the last of its eight
// register stages: the day split (offset, a 32x32 reciprocal multiply,
// remainder and correction) fills the first four, and the time-of-day and
// date splits fill the last four. A stalled output holds the pipeline; empty
// stages still fill, so bubbles close up. In mode 0
// the word's epoch seconds are turned into year (minus 2000), month, day,
// hour, minute and second; seconds before 2000 or from 2100 on set
// out_of_range and zero all calendar fields, while out_epoch_seconds always
// echoes the input. In mode 1 the calendar fields are echoed and summed into
// seconds since 1970, modulo 2^32, with no range checks on the fields.
module unix_time_calendar_converter_core (
  input  logic        clk,
  input  logic        rst,
  udc_in_if.sink      ingress,
  udc_out_if.source   egress
);

  localparam int NS = udc_pkg::NUM_STAGES;

  // Per-stage valid bits and load enables; a stage loads when it is empty or
  // when the stage after it moves on.
  logic [NS-1:0]   vld;
  logic [NS-1:0]   stg_en;
  udc_pkg::carry_t carry [NS];
  udc_pkg::carry_t cal_fold;
  logic            in_oor;

  logic [udc_pkg::DAYS_W-1:0] days3;
  logic [udc_pkg::SOD_W-1:0]  sod3;
  logic [31:0]                cal_epoch;
  logic [4:0]                 c_hour;
  logic [5:0]                 c_minute;
  logic [5:0]                 c_second;
  logic [6:0]                 c_year;
  logic [3:0]                 c_month;
  logic [4:0]                 c_day;

  always_comb begin
    stg_en[NS-1] = !vld[NS-1] || egress.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      stg_en[k] = !vld[k] || stg_en[k+1];
    end
  end

  assign ingress.ready = stg_en[0];

  assign in_oor = (ingress.data.epoch_seconds < udc_pkg::EPOCH_2000) ||
                  (ingress.data.epoch_seconds >= udc_pkg::EPOCH_2100);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (stg_en[0]) begin
        vld[0] <= ingress.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (stg_en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // The word entering the calendar stage: a mode 1 word takes the finished
  // calendar sum in place of its epoch seconds.
  always_comb begin
    cal_fold = carry[udc_pkg::CAL_STAGE-1];
    if (carry[udc_pkg::CAL_STAGE-1].word.mode == udc_pkg::MODE_TO_SECS) begin
      cal_fold.word.epoch_seconds = cal_epoch;
    end
  end

  // Side line carrying the input word; the calendar sum replaces the epoch
  // seconds of a mode 1 word once it is ready.
  always_ff @(posedge clk) begin
    if (stg_en[0]) begin
      carry[0].word <= ingress.data;
      carry[0].oor  <= in_oor;
    end
    for (int k = 1; k < NS; k++) begin
      if (stg_en[k]) begin
        carry[k] <= (k == udc_pkg::CAL_STAGE) ? cal_fold : carry[k-1];
      end
    end
  end

  udc_sec_split u_sec_split (
    .clk           (clk),
    .en            (stg_en[3:0]),
    .epoch_seconds (ingress.data.epoch_seconds),
    .days          (days3),
    .sod           (sod3)
  );

  udc_cal_sum u_cal_sum (
    .clk           (clk),
    .en            (stg_en[1:0]),
    .year          (ingress.data.year),
    .month         (ingress.data.month),
    .day           (ingress.data.day),
    .hour          (ingress.data.hour),
    .minute        (ingress.data.minute),
    .second        (ingress.data.second),
    .epoch_seconds (cal_epoch)
  );

  udc_tod_split u_tod_split (
    .clk    (clk),
    .en     (stg_en[7:4]),
    .sod    (sod3),
    .hour   (c_hour),
    .minute (c_minute),
    .second (c_second)
  );

  udc_date_split u_date_split (
    .clk   (clk),
    .en    (stg_en[7:4]),
    .days  (days3),
    .year  (c_year),
    .month (c_month),
    .day   (c_day)
  );

  // Result word: echo, zeroed fields on out-of-range seconds, or the split.
  always_comb begin
    egress.valid                  = vld[NS-1];
    egress.data.out_epoch_seconds = carry[NS-1].word.epoch_seconds;
    if (carry[NS-1].word.mode == udc_pkg::MODE_TO_SECS) begin
      egress.data.out_year     = carry[NS-1].word.year;
      egress.data.out_month    = carry[NS-1].word.month;
      egress.data.out_day      = carry[NS-1].word.day;
      egress.data.out_hour     = carry[NS-1].word.hour;
      egress.data.out_minute   = carry[NS-1].word.minute;
      egress.data.out_second   = carry[NS-1].word.second;
      egress.data.out_of_range = 1'b0;
    end else if (carry[NS-1].oor) begin
      egress.data.out_year     = '0;
      egress.data.out_month    = '0;
      egress.data.out_day      = '0;
      egress.data.out_hour     = '0;
      egress.data.out_minute   = '0;
      egress.data.out_second   = '0;
      egress.data.out_of_range = 1'b1;
    end else begin
      egress.data.out_year     = c_year;
      egress.data.out_month    = c_month;
      egress.data.out_day      = c_day;
      egress.data.out_hour     = c_hour;
      egress.data.out_minute   = c_minute;
      egress.data.out_second   = c_second;
      egress.data.out_of_range = 1'b0;
    end
  end

  // An accepted word always occupies the first stage on the next cycle.
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (ingress.valid && ingress.ready) |=> vld[0])
    else $error("accepted word did not enter the pipeline");

  // The day split must leave a second of day below one full day.
  a_sod_bound: assert property (@(posedge clk) disable iff (rst)
    (vld[3] && (carry[3].word.mode == udc_pkg::MODE_TO_CAL) && !carry[3].oor)
      |-> (sod3 < udc_pkg::SECS_PER_DAY))
    else $error("second of day out of bounds after correction");

  // In-range seconds must give a legal date.
  a_date_legal: assert property (@(posedge clk) disable iff (rst)
    (vld[NS-1] && (carry[NS-1].word.mode == udc_pkg::MODE_TO_CAL) && !carry[NS-1].oor)
      |-> ((c_month >= 4'd1) && (c_month <= 4'd12) && (c_day >= 5'd1) &&
           (c_year <= 7'd99)))
    else $error("date split produced an illegal date");

  // In-range seconds must give a legal time of day.
  a_time_legal: assert property (@(posedge clk) disable iff (rst)
    (vld[NS-1] && (carry[NS-1].word.mode == udc_pkg::MODE_TO_CAL) && !carry[NS-1].oor)
      |-> ((c_hour < 5'd24) && (c_minute < 6'd60) && (c_second < 6'd60)))
    else $error("time split produced an illegal time of day");

endmodule
